### rtl/core/rpc_pkg.sv
package rpc_pkg;

  // field widths
  localparam int ROW_W    = 8;
  localparam int CFG_W    = 4;
  localparam int WAYS_W   = 20;
  localparam int CHOICE_W = 4;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // choice stack code: row left empty
  localparam logic [CHOICE_W-1:0] CHOICE_NONE = 4'hF;
  // saturation limit of the placement count
  localparam logic [WAYS_W-1:0]   WAYS_MAX    = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // configuration register index (paddr[2])
  typedef enum logic {
    REG_BOARD_SIZE  = 1'b0,
    REG_PIECE_COUNT = 1'b1
  } reg_idx_t;

  // top level to search engine
  typedef struct packed {
    logic             row_we;
    logic [ROW_W-1:0] row_cells;
    logic             row_last;
    logic [CFG_W-1:0] board_size;
    logic [CFG_W-1:0] piece_count;
    logic             slot_free;
  } cmd_t;

  // search engine to top level
  typedef struct packed {
    logic idle;
    logic done;
  } sts_t;

endpackage

### rtl/core/rpc_search.sv
module rpc_search #(
  parameter int MAX_SIZE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rpc_pkg::cmd_t               cmd,
  output rpc_pkg::sts_t               sts,
  output logic [rpc_pkg::WAYS_W-1:0]  ways
);

  localparam int LVL_W = $clog2(MAX_SIZE + 1);
  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_SIZE);

  rpc_pkg::state_t state, state_next;

  // board store and search stack
  logic [rpc_pkg::ROW_W-1:0]    board_rows   [MAX_SIZE];
  logic [rpc_pkg::CHOICE_W-1:0] choice_stack [MAX_SIZE];

  logic [LVL_W-1:0]           load_ptr;
  logic [LVL_W-1:0]           level, level_next;
  logic                       ascend, ascend_next;
  logic [rpc_pkg::ROW_W-1:0]  used_cols, used_cols_next;
  logic [rpc_pkg::CFG_W-1:0]  pieces, pieces_next;
  logic [rpc_pkg::WAYS_W-1:0] ways_total, ways_total_next;
  logic [LVL_W-1:0]           rows_in_use, rows_in_use_next;
  logic [rpc_pkg::ROW_W-1:0]  col_limit, col_limit_next;

  logic                         ch_we;
  logic [rpc_pkg::CHOICE_W-1:0] ch_wdata;
  logic                         do_pop;
  logic                         done;

  logic [IDX_W-1:0]             idx;
  logic [rpc_pkg::CHOICE_W-1:0] cur_choice;
  logic [rpc_pkg::ROW_W-1:0]    cur_row;
  logic [LVL_W-1:0]             rows_sat;
  logic [rpc_pkg::ROW_W-1:0]    limit_sat;

  assign idx        = level[IDX_W-1:0];
  assign cur_choice = choice_stack[idx];
  assign cur_row    = board_rows[idx];

  // board size clipped to the store depth, and the columns it allows
  always_comb begin
    if (int'(cmd.board_size) > MAX_SIZE) begin
      rows_sat = LVL_MAX;
    end else begin
      rows_sat = LVL_W'(cmd.board_size);
    end
    for (int c = 0; c < rpc_pkg::ROW_W; c++) begin
      limit_sat[c] = (c < int'(rows_sat));
    end
  end

  // search sequencer: one tree step per cycle
  always_comb begin
    logic                         placed;
    logic [rpc_pkg::ROW_W-1:0]    used_eff;
    logic [rpc_pkg::CFG_W-1:0]    pieces_eff;
    logic [rpc_pkg::CHOICE_W-1:0] start;
    logic [rpc_pkg::ROW_W-1:0]    cand;
    logic [rpc_pkg::CHOICE_W-1:0] first;

    state_next       = state;
    level_next       = level;
    ascend_next      = ascend;
    used_cols_next   = used_cols;
    pieces_next      = pieces;
    ways_total_next  = ways_total;
    rows_in_use_next = rows_in_use;
    col_limit_next   = col_limit;
    ch_we            = 1'b0;
    ch_wdata         = rpc_pkg::CHOICE_NONE;
    do_pop           = 1'b0;
    done             = 1'b0;

    // undo the piece this row holds, then look for the next free column
    placed     = (cur_choice != rpc_pkg::CHOICE_NONE);
    used_eff   = placed ? (used_cols & ~(rpc_pkg::ROW_W'(1) << cur_choice)) : used_cols;
    pieces_eff = placed ? (pieces + rpc_pkg::CFG_W'(1)) : pieces;
    start      = placed ? (cur_choice + rpc_pkg::CHOICE_W'(1)) : '0;
    cand       = cur_row & ~used_eff & col_limit & (rpc_pkg::ROW_W'('1) << start);
    first      = '0;
    for (int c = rpc_pkg::ROW_W - 1; c >= 0; c--) begin
      if (cand[c]) begin
        first = rpc_pkg::CHOICE_W'(c);
      end
    end

    unique case (state)
      rpc_pkg::ST_IDLE: begin
        if (cmd.row_we && cmd.row_last) begin
          state_next       = rpc_pkg::ST_SEARCH;
          level_next       = '0;
          ascend_next      = 1'b0;
          used_cols_next   = '0;
          pieces_next      = cmd.piece_count;
          ways_total_next  = '0;
          rows_in_use_next = rows_sat;
          col_limit_next   = limit_sat;
        end
      end
      rpc_pkg::ST_SEARCH: begin
        if (!ascend) begin
          if (pieces == '0) begin
            if (ways_total != rpc_pkg::WAYS_MAX) begin
              ways_total_next = ways_total + rpc_pkg::WAYS_W'(1);
            end
            do_pop = 1'b1;
          end else if (level >= rows_in_use) begin
            do_pop = 1'b1;
          end else begin
            // first branch: leave this row empty
            ch_we       = 1'b1;
            ch_wdata    = rpc_pkg::CHOICE_NONE;
            level_next  = level + LVL_W'(1);
          end
        end else begin
          if (|cand) begin
            ch_we          = 1'b1;
            ch_wdata       = first;
            used_cols_next = used_eff | (rpc_pkg::ROW_W'(1) << first);
            pieces_next    = pieces_eff - rpc_pkg::CFG_W'(1);
            level_next     = level + LVL_W'(1);
            ascend_next    = 1'b0;
          end else begin
            used_cols_next = used_eff;
            pieces_next    = pieces_eff;
            do_pop         = 1'b1;
          end
        end
      end
      rpc_pkg::ST_DONE: begin
        if (cmd.slot_free) begin
          done       = 1'b1;
          state_next = rpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rpc_pkg::ST_IDLE;
      end
    endcase

    // return to the row above, or finish at the top
    if (do_pop) begin
      if (level == '0) begin
        state_next = rpc_pkg::ST_DONE;
      end else begin
        level_next  = level - LVL_W'(1);
        ascend_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rpc_pkg::ST_IDLE;
      load_ptr    <= '0;
      level       <= '0;
      ascend      <= 1'b0;
      used_cols   <= '0;
      pieces      <= '0;
      ways_total  <= '0;
      rows_in_use <= '0;
      col_limit   <= '0;
    end else begin
      state       <= state_next;
      level       <= level_next;
      ascend      <= ascend_next;
      used_cols   <= used_cols_next;
      pieces      <= pieces_next;
      ways_total  <= ways_total_next;
      rows_in_use <= rows_in_use_next;
      col_limit   <= col_limit_next;
      // row pointer: saturates at the store depth, back to zero on the last row
      if (cmd.row_we) begin
        if (cmd.row_last) begin
          load_ptr <= '0;
        end else if (load_ptr < LVL_MAX) begin
          load_ptr <= load_ptr + LVL_W'(1);
        end
      end
    end
  end

  // board store write
  always_ff @(posedge clk) begin
    if (cmd.row_we && (load_ptr < LVL_MAX)) begin
      board_rows[load_ptr[IDX_W-1:0]] <= cmd.row_cells;
    end
  end

  // choice stack write
  always_ff @(posedge clk) begin
    if (ch_we) begin
      choice_stack[idx] <= ch_wdata;
    end
  end

  assign sts.idle = (state == rpc_pkg::ST_IDLE);
  assign sts.done = done;
  assign ways     = ways_total;

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rpc_pkg::ST_SEARCH) |-> (level <= rows_in_use))
    else $error("search level beyond board rows");

  a_done_slot: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (cmd.slot_free && (state == rpc_pkg::ST_DONE)))
    else $error("result handed over without a free slot");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.row_we |-> (state == rpc_pkg::ST_IDLE))
    else $error("row beat taken during search");

  a_ways_mono: assert property (@(posedge clk) disable iff (rst)
    (state == rpc_pkg::ST_SEARCH) |=> (ways_total >= $past(ways_total)))
    else $error("placement count went down during search");

  a_cols_pieces: assert property (@(posedge clk) disable iff (rst)
    ((state == rpc_pkg::ST_SEARCH) && (level == '0) && !ascend)
      |-> (used_cols == '0))
    else $error("columns still taken at search start");
`endif

endmodule

### rtl/core/rook_placement_counter_unit.sv
// channel | signals                                   | beat taken when
// --------+-------------------------------------------+--------------------------------
// in      | in_valid, in_ready, row_cells, row_last   | in_valid && in_ready
// out     | out_valid, out_ready, ways                | out_valid && out_ready
// cfg     | psel, penable, pwrite, paddr, pwdata ...  | psel && penable && pwrite
//
// A row without row_last is stored in the board. A last row starts a depth-first search with
// one tree step per row entry and one per return to a row, then hands the count over.
// Reset (rst, synchronous) clears control state; stored rows are undefined until written.
// in_ready is low from the last-row beat until the count is in the output register.
// A count waiting in the output register does not block loading of the next board.
module rook_placement_counter_unit #(
  parameter int MAX_SIZE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpc_pkg::DATA_W-1:0]  pwdata,
  output logic [rpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // row input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpc_pkg::ROW_W-1:0]   row_cells,
  input  logic                        row_last,
  // count output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rpc_pkg::WAYS_W-1:0]  ways
);

  logic [rpc_pkg::CFG_W-1:0]  board_size;
  logic [rpc_pkg::CFG_W-1:0]  piece_count;
  rpc_pkg::reg_idx_t          reg_idx;
  rpc_pkg::cmd_t              cmd;
  rpc_pkg::sts_t              sts;
  logic [rpc_pkg::WAYS_W-1:0] eng_ways;

  assign pready  = 1'b1;
  assign reg_idx = rpc_pkg::reg_idx_t'(paddr[2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      board_size  <= rpc_pkg::CFG_W'(8);
      piece_count <= rpc_pkg::CFG_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        rpc_pkg::REG_BOARD_SIZE:  board_size  <= pwdata[rpc_pkg::CFG_W-1:0];
        rpc_pkg::REG_PIECE_COUNT: piece_count <= pwdata[rpc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      rpc_pkg::REG_BOARD_SIZE:  prdata = rpc_pkg::DATA_W'(board_size);
      rpc_pkg::REG_PIECE_COUNT: prdata = rpc_pkg::DATA_W'(piece_count);
      default:                  prdata = '0;
    endcase
  end

  assign in_ready = sts.idle;

  always_comb begin
    cmd.row_we      = in_valid && in_ready;
    cmd.row_cells   = row_cells;
    cmd.row_last    = row_last;
    cmd.board_size  = board_size;
    cmd.piece_count = piece_count;
    cmd.slot_free   = !out_valid || out_ready;
  end

  rpc_search #(
    .MAX_SIZE (MAX_SIZE)
  ) u_search (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .sts  (sts),
    .ways (eng_ways)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      ways <= eng_ways;
    end
  end

endmodule
